>>> hw/rtl/three_band_audio_equalizer_assert.svh
// assertion macros for the equalizer port checker
`ifndef THREE_BAND_AUDIO_EQUALIZER_ASSERT_SVH
`define THREE_BAND_AUDIO_EQUALIZER_ASSERT_SVH

// checked on every rising edge of clk_i outside reset
`define TBEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every rising edge of clk_i, reset included
`define TBEQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> hw/rtl/tbeq_pkg.sv
// shared types, constants and microprogram of the three-band equalizer
`timescale 1ns / 1ps

package tbeq_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int SAMPLE_BITS_DEF  = 24;

  localparam int CHAN_W      = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 20;
  localparam int COEF_W      = 17;
  localparam int GAIN_W      = 20;
  localparam int POLE_W      = 32;
  localparam int POLES       = 4;
  localparam int HIST        = 3;
  localparam int COEF_FRAC_W = 16;
  localparam int ACC_FRAC_W  = 48;
  localparam int MUL_A_W     = POLE_W + 1;
  localparam int MUL_B_W     = GAIN_W + 1;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int ACC_W       = PROD_W + 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_COEF  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_COEF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MID_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_GAIN = 3'd4;

  localparam logic [COEF_W-1:0] LOW_COEF_RST  = 17'd7547;
  localparam logic [COEF_W-1:0] HIGH_COEF_RST = 17'd42131;
  localparam logic [GAIN_W-1:0] GAIN_RST      = 20'd65536;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // microprogram addresses
  localparam step_t ST_LOAD   = 4'd0;
  localparam step_t ST_L0     = 4'd1;
  localparam step_t ST_L0_H0  = 4'd2;
  localparam step_t ST_H0_L1  = 4'd3;
  localparam step_t ST_L1_H1  = 4'd4;
  localparam step_t ST_H1_L2  = 4'd5;
  localparam step_t ST_L2_H2  = 4'd6;
  localparam step_t ST_H2_L3  = 4'd7;
  localparam step_t ST_L3_H3  = 4'd8;
  localparam step_t ST_H3_LG  = 4'd9;
  localparam step_t ST_MG     = 4'd10;
  localparam step_t ST_HG     = 4'd11;
  localparam step_t ST_ACC    = 4'd12;
  localparam step_t ST_FINISH = 4'd13;
  localparam step_t ST_ZERO   = 4'd14;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_LOW,
    MUL_HIGH,
    MUL_LO_G,
    MUL_MID_G,
    MUL_HI_G
  } mul_sel_e;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_LOW,
    UPD_HIGH
  } upd_sel_e;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_BAD_CHAN,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    logic     load;
    mul_sel_e mul_sel;
    logic     first;
    upd_sel_e upd_sel;
    acc_op_e  acc_op;
    logic     finish;
    logic     zero_out;
    cond_e    cond;
    step_t    target;
    logic     last;
  } uword_t;

  typedef struct packed {
    logic bad_chan;
    logic out_busy;
  } stat_t;

  // control store: the two cascades interleave on one multiplier
  function automatic uword_t tbeq_ucode(step_t s);
    uword_t w;
    w = '0;
    unique case (s)
      ST_LOAD: begin
        w.load   = 1'b1;
        w.cond   = COND_BAD_CHAN;
        w.target = ST_ZERO;
      end
      ST_L0: begin
        w.mul_sel = MUL_LOW;
        w.first   = 1'b1;
      end
      ST_L0_H0: begin
        w.upd_sel = UPD_LOW;
        w.mul_sel = MUL_HIGH;
        w.first   = 1'b1;
      end
      ST_H0_L1, ST_H1_L2, ST_H2_L3: begin
        w.upd_sel = UPD_HIGH;
        w.mul_sel = MUL_LOW;
      end
      ST_L1_H1, ST_L2_H2, ST_L3_H3: begin
        w.upd_sel = UPD_LOW;
        w.mul_sel = MUL_HIGH;
      end
      ST_H3_LG: begin
        w.upd_sel = UPD_HIGH;
        w.mul_sel = MUL_LO_G;
      end
      ST_MG: begin
        w.acc_op  = ACC_LOAD;
        w.mul_sel = MUL_MID_G;
      end
      ST_HG: begin
        w.acc_op  = ACC_ADD;
        w.mul_sel = MUL_HI_G;
      end
      ST_ACC: begin
        w.acc_op = ACC_ADD;
      end
      ST_FINISH: begin
        w.finish = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.target = ST_FINISH;
        w.last   = 1'b1;
      end
      ST_ZERO: begin
        w.zero_out = 1'b1;
        w.cond     = COND_OUT_BUSY;
        w.target   = ST_ZERO;
        w.last     = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/tbeq_state_mem.sv
// per-channel filter state memory with per-row valid flags
`timescale 1ns / 1ps

module tbeq_state_mem #(
  parameter int NUM_CHANNELS = tbeq_pkg::NUM_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = tbeq_pkg::SAMPLE_BITS_DEF,
  localparam int AW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
  localparam int ROW_W = 2 * tbeq_pkg::POLES * tbeq_pkg::POLE_W + tbeq_pkg::HIST * SAMPLE_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [ROW_W-1:0] rd_data_o,
  output logic             rd_vld_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [ROW_W-1:0] wr_data_i
);
  import tbeq_pkg::*;

  logic [ROW_W-1:0]        mem_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld_q;
  logic [ROW_W-1:0]        rd_data_q;
  logic                    rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // a row never written reads back with its valid flag low
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign rd_vld_o  = rd_vld_q;

endmodule

>>> hw/rtl/tbeq_seq.sv
// microprogram sequencer: step counter, control store and jumps
`timescale 1ns / 1ps

module tbeq_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  tbeq_pkg::stat_t  stat_i,
  output tbeq_pkg::uword_t ctl_o,
  output logic             busy_o
);
  import tbeq_pkg::*;

  step_t  step_q, step_d;
  logic   busy_q, busy_d;
  uword_t uw;
  logic   cond_hit;
  logic   jump;

  assign uw = tbeq_ucode(step_q);

  always_comb begin
    unique case (uw.cond)
      COND_NONE:     cond_hit = 1'b0;
      COND_BAD_CHAN: cond_hit = stat_i.bad_chan;
      COND_OUT_BUSY: cond_hit = stat_i.out_busy;
      default:       cond_hit = 1'b0;
    endcase
  end

  assign jump = busy_q & cond_hit;

  // a last step that jumps onto itself waits and does nothing
  always_comb begin
    ctl_o = busy_q ? uw : '0;
    if (jump && uw.last) begin
      ctl_o.finish   = 1'b0;
      ctl_o.zero_out = 1'b0;
    end
  end

  always_comb begin
    step_d = step_q;
    busy_d = busy_q;
    priority if (!busy_q) begin
      busy_d = start_i;
      step_d = ST_LOAD;
    end else if (jump) begin
      step_d = uw.target;
    end else if (uw.last) begin
      busy_d = 1'b0;
    end else begin
      step_d = STEP_W'(step_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_LOAD;
      busy_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
    end
  end

  assign busy_o = busy_q;

endmodule

>>> hw/rtl/tbeq_dp.sv
// equalizer datapath: working registers, shared multiplier, accumulator, output word
`timescale 1ns / 1ps

module tbeq_dp #(
  parameter int NUM_CHANNELS = tbeq_pkg::NUM_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = tbeq_pkg::SAMPLE_BITS_DEF,
  localparam int AW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
  localparam int ROW_W = 2 * tbeq_pkg::POLES * tbeq_pkg::POLE_W + tbeq_pkg::HIST * SAMPLE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tbeq_pkg::uword_t                    ctl_i,
  output tbeq_pkg::stat_t                     stat_o,
  input  logic                                accept_i,
  input  logic [tbeq_pkg::CHAN_W-1:0]         chan_i,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  input  logic [tbeq_pkg::COEF_W-1:0]         low_coef_i,
  input  logic [tbeq_pkg::COEF_W-1:0]         high_coef_i,
  input  logic [tbeq_pkg::GAIN_W-1:0]         low_gain_i,
  input  logic [tbeq_pkg::GAIN_W-1:0]         mid_gain_i,
  input  logic [tbeq_pkg::GAIN_W-1:0]         high_gain_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic [tbeq_pkg::CHAN_W-1:0]         chan_out_o,
  output logic signed [SAMPLE_BITS-1:0]       sample_out_o,
  output logic                                rd_en_o,
  output logic [AW-1:0]                       rd_addr_o,
  input  logic [ROW_W-1:0]                    rd_data_i,
  input  logic                                rd_vld_i,
  output logic                                wr_en_o,
  output logic [AW-1:0]                       wr_addr_o,
  output logic [ROW_W-1:0]                    wr_data_o
);
  import tbeq_pkg::*;

  localparam int UP      = POLE_W - SAMPLE_BITS;
  localparam int DOWN    = ACC_FRAC_W - SAMPLE_BITS;
  localparam int SUM_W   = PROD_W - COEF_FRAC_W + 1;
  localparam int RND_W   = ACC_W + 1;
  localparam int HP_BASE = POLES * POLE_W;
  localparam int HI_BASE = 2 * POLES * POLE_W;
  localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) <<< (DOWN - 1);

  logic [CHAN_W-1:0]              chan_q;
  logic signed [SAMPLE_BITS-1:0]  sample_q;
  logic signed [POLE_W-1:0]       lp_q [POLES];
  logic signed [POLE_W-1:0]       hp_q [POLES];
  logic signed [SAMPLE_BITS-1:0]  hist_q [HIST];
  logic signed [PROD_W-1:0]       prod_q;
  logic signed [ACC_W-1:0]        acc_q;
  logic                           out_vld_q;
  logic [CHAN_W-1:0]              chan_out_q;
  logic signed [SAMPLE_BITS-1:0]  sample_out_q;

  logic signed [POLE_W-1:0]       x_w, d3_w, upd_p, upd_new;
  logic signed [MUL_A_W-1:0]      mul_a;
  logic signed [MUL_B_W-1:0]      mul_b;
  logic signed [PROD_W-1:0]       prod_w;
  logic signed [SUM_W-1:0]        upd_sum;
  logic [SUM_W-POLE_W:0]          upd_top;
  logic signed [RND_W-1:0]        rnd_sum, rnd_shr;
  logic [RND_W-SAMPLE_BITS:0]     rnd_top;
  logic signed [SAMPLE_BITS-1:0]  rnd_sat;
  logic                           chan_in_ok;

  // sample scaled up to the pole format, and the input three samples back
  assign x_w  = POLE_W'(sample_q) <<< UP;
  assign d3_w = POLE_W'(hist_q[HIST-1]) <<< UP;

  // operand select: the pole in work always sits at slot 0, its source at the last slot
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctl_i.mul_sel)
      MUL_NONE: ;
      MUL_LOW: begin
        mul_a = MUL_A_W'(ctl_i.first ? x_w : lp_q[POLES-1]) - MUL_A_W'(lp_q[0]);
        mul_b = MUL_B_W'(low_coef_i);
      end
      MUL_HIGH: begin
        mul_a = MUL_A_W'(ctl_i.first ? x_w : hp_q[POLES-1]) - MUL_A_W'(hp_q[0]);
        mul_b = MUL_B_W'(high_coef_i);
      end
      MUL_LO_G: begin
        mul_a = MUL_A_W'(lp_q[POLES-1]);
        mul_b = MUL_B_W'(low_gain_i);
      end
      MUL_MID_G: begin
        // delayed input minus low minus high reduces to high pole minus low pole
        mul_a = MUL_A_W'(hp_q[POLES-1]) - MUL_A_W'(lp_q[POLES-1]);
        mul_b = MUL_B_W'(mid_gain_i);
      end
      MUL_HI_G: begin
        mul_a = MUL_A_W'(d3_w) - MUL_A_W'(hp_q[POLES-1]);
        mul_b = MUL_B_W'(high_gain_i);
      end
      default: ;
    endcase
  end

  assign prod_w = mul_a * mul_b;

  // pole update with floor shift and saturation to 32 bits
  assign upd_p   = (ctl_i.upd_sel == UPD_HIGH) ? hp_q[0] : lp_q[0];
  assign upd_sum = SUM_W'(upd_p) + SUM_W'(prod_q >>> COEF_FRAC_W);
  assign upd_top = upd_sum[SUM_W-1:POLE_W-1];

  always_comb begin
    if ((&upd_top) || !(|upd_top)) begin
      upd_new = upd_sum[POLE_W-1:0];
    end else if (upd_sum[SUM_W-1]) begin
      upd_new = {1'b1, {(POLE_W-1){1'b0}}};
    end else begin
      upd_new = {1'b0, {(POLE_W-1){1'b1}}};
    end
  end

  // round half up to the sample format and saturate
  assign rnd_sum = RND_W'(acc_q) + RND_HALF;
  assign rnd_shr = rnd_sum >>> DOWN;
  assign rnd_top = rnd_shr[RND_W-1:SAMPLE_BITS-1];

  always_comb begin
    if ((&rnd_top) || !(|rnd_top)) begin
      rnd_sat = rnd_shr[SAMPLE_BITS-1:0];
    end else if (rnd_shr[RND_W-1]) begin
      rnd_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      rnd_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      chan_q   <= chan_i;
      sample_q <= sample_i;
    end
    if (ctl_i.load) begin
      for (int i = 0; i < POLES; i++) begin
        lp_q[i] <= rd_vld_i ? rd_data_i[i*POLE_W +: POLE_W] : '0;
        hp_q[i] <= rd_vld_i ? rd_data_i[HP_BASE + i*POLE_W +: POLE_W] : '0;
      end
      for (int i = 0; i < HIST; i++) begin
        hist_q[i] <= rd_vld_i ? rd_data_i[HI_BASE + i*SAMPLE_BITS +: SAMPLE_BITS] : '0;
      end
    end
    // each update rotates its cascade by one pole
    unique case (ctl_i.upd_sel)
      UPD_NONE: ;
      UPD_LOW: begin
        for (int i = 0; i < POLES - 1; i++) begin
          lp_q[i] <= lp_q[i+1];
        end
        lp_q[POLES-1] <= upd_new;
      end
      UPD_HIGH: begin
        for (int i = 0; i < POLES - 1; i++) begin
          hp_q[i] <= hp_q[i+1];
        end
        hp_q[POLES-1] <= upd_new;
      end
      default: ;
    endcase
    if (ctl_i.mul_sel != MUL_NONE) begin
      prod_q <= prod_w;
    end
    unique case (ctl_i.acc_op)
      ACC_NONE: ;
      ACC_LOAD: acc_q <= ACC_W'(prod_q);
      ACC_ADD:  acc_q <= acc_q + ACC_W'(prod_q);
      default: ;
    endcase
    if (ctl_i.finish) begin
      chan_out_q   <= chan_q;
      sample_out_q <= rnd_sat;
    end else if (ctl_i.zero_out) begin
      chan_out_q   <= chan_q;
      sample_out_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctl_i.finish || ctl_i.zero_out) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // row write-back: updated poles and the shifted input history
  always_comb begin
    wr_data_o = '0;
    for (int i = 0; i < POLES; i++) begin
      wr_data_o[i*POLE_W +: POLE_W]           = lp_q[i];
      wr_data_o[HP_BASE + i*POLE_W +: POLE_W] = hp_q[i];
    end
    wr_data_o[HI_BASE +: SAMPLE_BITS] = sample_q;
    for (int i = 1; i < HIST; i++) begin
      wr_data_o[HI_BASE + i*SAMPLE_BITS +: SAMPLE_BITS] = hist_q[i-1];
    end
  end

  assign chan_in_ok = 32'(chan_i) < 32'(NUM_CHANNELS);
  assign rd_en_o    = accept_i & chan_in_ok;
  assign rd_addr_o  = AW'(chan_i);
  assign wr_en_o    = ctl_i.finish;
  assign wr_addr_o  = AW'(chan_q);

  assign stat_o.bad_chan = !(32'(chan_q) < 32'(NUM_CHANNELS));
  assign stat_o.out_busy = out_vld_q & out_stall_i;

  assign out_valid_o  = out_vld_q;
  assign chan_out_o   = chan_out_q;
  assign sample_out_o = sample_out_q;

endmodule

>>> hw/rtl/three_band_audio_equalizer.sv
// three-band equalizer top: config registers, sequencer, datapath, state memory
// flow: the state row is read on acceptance, the microprogram runs both cascades,
//   gains and accumulator, and the result goes to the output register; a channel
//   index at or above NUM_CHANNELS gets a zero result. One word at a time; the eleven
//   products of one sample share a single 33x21 multiplier stepped by the microprogram
// reset: config registers take their defaults; channel state reads as zero through
//   per-channel valid flags, so there is no clearing pass
`timescale 1ns / 1ps

module three_band_audio_equalizer #(
  parameter int NUM_CHANNELS = tbeq_pkg::NUM_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = tbeq_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input word
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [tbeq_pkg::CHAN_W-1:0]        chan_i,
  input  logic signed [SAMPLE_BITS-1:0]      sample_in_i,
  // result word
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [tbeq_pkg::CHAN_W-1:0]        chan_out_o,
  output logic signed [SAMPLE_BITS-1:0]      sample_out_o,
  // register writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tbeq_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tbeq_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import tbeq_pkg::*;

  localparam int AW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ROW_W = 2 * POLES * POLE_W + HIST * SAMPLE_BITS;

  logic [COEF_W-1:0] low_coef_q, high_coef_q;
  logic [GAIN_W-1:0] low_gain_q, mid_gain_q, high_gain_q;

  logic             accept;
  logic             busy;
  uword_t           ctl;
  stat_t            stat;
  logic             rd_en, rd_vld, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [ROW_W-1:0] rd_data, wr_data;

  // registers are always writable; software must write them only while idle, unchecked
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_coef_q  <= LOW_COEF_RST;
      high_coef_q <= HIGH_COEF_RST;
      low_gain_q  <= GAIN_RST;
      mid_gain_q  <= GAIN_RST;
      high_gain_q <= GAIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_LOW_COEF:  low_coef_q  <= cfg_data_i[COEF_W-1:0];
        REG_HIGH_COEF: high_coef_q <= cfg_data_i[COEF_W-1:0];
        REG_LOW_GAIN:  low_gain_q  <= cfg_data_i[GAIN_W-1:0];
        REG_MID_GAIN:  mid_gain_q  <= cfg_data_i[GAIN_W-1:0];
        REG_HIGH_GAIN: high_gain_q <= cfg_data_i[GAIN_W-1:0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // one word in flight; the output register lets the next word in
  // while a finished result still waits downstream
  assign in_stall_o = busy;
  assign accept     = in_valid_i & ~in_stall_o;

  tbeq_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .stat_i  (stat),
    .ctl_o   (ctl),
    .busy_o  (busy)
  );

  tbeq_dp #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .stat_o       (stat),
    .accept_i     (accept),
    .chan_i       (chan_i),
    .sample_i     (sample_in_i),
    .low_coef_i   (low_coef_q),
    .high_coef_i  (high_coef_q),
    .low_gain_i   (low_gain_q),
    .mid_gain_i   (mid_gain_q),
    .high_gain_i  (high_gain_q),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .chan_out_o   (chan_out_o),
    .sample_out_o (sample_out_o),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .rd_vld_i     (rd_vld),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data)
  );

  // state row is read on acceptance and written back in the finish step
  tbeq_state_mem #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .rd_vld_o  (rd_vld),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

endmodule

>>> hw/rtl/tbeq_chk.sv
// port-level checker for the three-band equalizer and its bind
`timescale 1ns / 1ps
`include "three_band_audio_equalizer_assert.svh"

module tbeq_chk #(
  parameter int SAMPLE_BITS = tbeq_pkg::SAMPLE_BITS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [tbeq_pkg::CHAN_W-1:0]   chan_out_o,
  input logic [SAMPLE_BITS-1:0]        sample_out_o,
  input logic                          cfg_ready_o
);
  import tbeq_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i & ~in_stall_o;

  // one word at a time: an accepted word blocks the next cycle
  `TBEQ_ASSERT(a_busy_after_accept, in_acc |=> in_stall_o, "word accepted while busy")
  // a result never appears right after acceptance
  `TBEQ_ASSERT(a_no_instant_result, in_acc |=> !$rose(out_valid_o), "result too early")
  // the step that produces a result also frees the input
  `TBEQ_ASSERT(a_idle_on_result, $rose(out_valid_o) |-> !in_stall_o, "busy after result")
  // a stalled result holds
  `TBEQ_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(chan_out_o) && $stable(sample_out_o), "stalled result changed")
  `TBEQ_ASSERT_ALWAYS(a_cfg_ready, cfg_ready_o, "register port not ready")

endmodule

bind three_band_audio_equalizer tbeq_chk #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_tbeq_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .chan_out_o   (chan_out_o),
  .sample_out_o (sample_out_o),
  .cfg_ready_o  (cfg_ready_o)
);

>>> tb/sv/three_band_audio_equalizer_checker.sv
// checker for the three-band equalizer: predicts every result word and compares
`timescale 1ns / 1ps

module three_band_audio_equalizer_checker #(
  parameter int NUM_CHANNELS = tbeq_pkg::NUM_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = tbeq_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic [tbeq_pkg::CHAN_W-1:0]        chan_i,
  input  logic signed [SAMPLE_BITS-1:0]      sample_in_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic [tbeq_pkg::CHAN_W-1:0]        chan_out_i,
  input  logic signed [SAMPLE_BITS-1:0]      sample_out_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [tbeq_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tbeq_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 checked_o
);
  import tbeq_pkg::*;

  localparam int     UP_SHIFT   = POLE_W - SAMPLE_BITS;
  localparam int     DOWN_SHIFT = ACC_FRAC_W - SAMPLE_BITS;
  localparam longint POLE_MAX   = (longint'(1) <<< (POLE_W - 1)) - 1;
  localparam longint POLE_MIN   = -POLE_MAX - 1;
  localparam longint OUT_MAX    = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint OUT_MIN    = -OUT_MAX - 1;
  localparam int     REPORT_MAX = 10;

  typedef struct {
    logic [CHAN_W-1:0]             chan;
    logic signed [SAMPLE_BITS-1:0] sample;
  } eq_word_t;

  eq_word_t expected_words[$];

  logic [COEF_W-1:0] low_coef, high_coef;
  logic [GAIN_W-1:0] low_gain, mid_gain, high_gain;

  logic signed [POLE_W-1:0]      low_pole  [NUM_CHANNELS][POLES];
  logic signed [POLE_W-1:0]      high_pole [NUM_CHANNELS][POLES];
  logic signed [SAMPLE_BITS-1:0] history   [NUM_CHANNELS][HIST];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // one four-pole cascade: p += floor(coef * (src - p) / 2^16), saturated
  function automatic void step_cascade(bit high_side, int unsigned ch, longint x);
    longint src, p, nxt;
    logic [COEF_W-1:0] c;
    c = high_side ? high_coef : low_coef;
    for (int k = 0; k < POLES; k++) begin
      p = high_side ? high_pole[ch][k] : low_pole[ch][k];
      if (k == 0) src = x;
      else src = high_side ? high_pole[ch][k-1] : low_pole[ch][k-1];
      nxt = sat(p + (((src - p) * longint'(c)) >>> COEF_FRAC_W), POLE_MIN, POLE_MAX);
      if (high_side) high_pole[ch][k] = nxt[POLE_W-1:0];
      else low_pole[ch][k] = nxt[POLE_W-1:0];
    end
  endfunction

  function automatic eq_word_t equalize(logic [CHAN_W-1:0] ch,
                                        logic signed [SAMPLE_BITS-1:0] s);
    eq_word_t w;
    longint x, d3, lo, hi, mid, acc;
    w.chan   = ch;
    w.sample = '0;
    // unused channel: zero out, no state touched
    if (ch >= NUM_CHANNELS) return w;
    x = longint'(s) <<< UP_SHIFT;
    step_cascade(1'b0, ch, x);
    step_cascade(1'b1, ch, x);
    d3  = longint'(history[ch][HIST-1]) <<< UP_SHIFT;
    lo  = longint'(low_pole[ch][POLES-1]);
    hi  = d3 - longint'(high_pole[ch][POLES-1]);
    mid = d3 - (hi + lo);
    for (int k = HIST - 1; k > 0; k--) history[ch][k] = history[ch][k-1];
    history[ch][0] = s;
    acc = lo * longint'(low_gain) + mid * longint'(mid_gain) + hi * longint'(high_gain);
    acc = (acc + (longint'(1) <<< (DOWN_SHIFT - 1))) >>> DOWN_SHIFT;
    w.sample = SAMPLE_BITS'(sat(acc, OUT_MIN, OUT_MAX));
    return w;
  endfunction

  function automatic void note_failure(string msg);
    fail_count_o++;
    if (fail_count_o <= REPORT_MAX) $display("%0t: %s", $time, msg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    eq_word_t want;
    if (!rst_ni) begin
      expected_words.delete();
      low_coef  = LOW_COEF_RST;
      high_coef = HIGH_COEF_RST;
      low_gain  = GAIN_RST;
      mid_gain  = GAIN_RST;
      high_gain = GAIN_RST;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        for (int k = 0; k < POLES; k++) begin
          low_pole[c][k]  = '0;
          high_pole[c][k] = '0;
        end
        for (int k = 0; k < HIST; k++) history[c][k] = '0;
      end
    end else begin
      // results first, so a word leaving and one arriving on the same edge stay in order
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          note_failure($sformatf("result word with nothing expected: chan %0d sample %0d",
                                 chan_out_i, sample_out_i));
        end else begin
          want = expected_words.pop_front();
          checked_o++;
          if (chan_out_i !== want.chan)
            note_failure($sformatf("chan_out mismatch: expected %0d, got %0d",
                                   want.chan, chan_out_i));
          if (sample_out_i !== want.sample)
            note_failure($sformatf("sample_out mismatch on chan %0d: expected %0d, got %0d",
                                   want.chan, want.sample, sample_out_i));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_LOW_COEF:  low_coef  = cfg_data_i[COEF_W-1:0];
          REG_HIGH_COEF: high_coef = cfg_data_i[COEF_W-1:0];
          REG_LOW_GAIN:  low_gain  = cfg_data_i[GAIN_W-1:0];
          REG_MID_GAIN:  mid_gain  = cfg_data_i[GAIN_W-1:0];
          REG_HIGH_GAIN: high_gain = cfg_data_i[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) expected_words.push_back(equalize(chan_i, sample_in_i));
    end
    pending_o = expected_words.size();
  end

endmodule

>>> tb/sv/tb_three_band_audio_equalizer.sv
// testbench top for the three-band equalizer: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_three_band_audio_equalizer;
  import tbeq_pkg::*;

  localparam int     NUM_CH       = NUM_CHANNELS_DEF;
  localparam int     SB           = SAMPLE_BITS_DEF;
  localparam int     CLK_PERIOD   = 20;
  localparam int     RESET_CYCLES = 7;
  // idle time after the last expected word before touching registers or ending
  localparam int     SETTLE       = 30;
  localparam int     CYCLE_LIMIT  = 600_000;
  localparam int     PHASE_WORDS  = 100;
  localparam int     NUM_PHASES   = 6;
  localparam longint SAMPLE_MAX   = (longint'(1) <<< (SB - 1)) - 1;
  localparam longint SAMPLE_MIN   = -SAMPLE_MAX - 1;
  // step size of the slow per-channel walk that feeds the filters tone-like input
  localparam longint SLEW         = 200_000;
  localparam logic [COEF_W-1:0]     COEF_MAX  = '1;
  localparam logic [GAIN_W-1:0]     GAIN_MAX  = '1;
  localparam logic [CFG_IDX_W-1:0]  REG_SPARE_FIRST = REG_HIGH_GAIN + 1'b1;
  localparam logic [CFG_IDX_W-1:0]  REG_SPARE_LAST  = '1;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [CHAN_W-1:0]         chan_i;
  logic signed [SB-1:0]      sample_in_i;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [CHAN_W-1:0]         chan_out_o;
  logic signed [SB-1:0]      sample_out_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i;
  logic [CFG_DATA_W-1:0]     cfg_data_i;

  int fail_count, pending, checked;
  int cycle_count = 0;
  int stall_left  = 0;
  int words_sent  = 0;
  int settings    = 1;      // the reset values count as the first setting
  bit out_quiet   = 1'b1;   // receiver never stalls while set
  bit in_quiet    = 1'b1;   // sender never leaves gaps while set
  longint walk [1 << CHAN_W];
  logic [CHAN_W-1:0] last_chan = '0;

  three_band_audio_equalizer #(
    .NUM_CHANNELS (NUM_CH),
    .SAMPLE_BITS  (SB)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .chan_i       (chan_i),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .chan_out_o   (chan_out_o),
    .sample_out_o (sample_out_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  three_band_audio_equalizer_checker #(
    .NUM_CHANNELS (NUM_CH),
    .SAMPLE_BITS  (SB)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .chan_i       (chan_i),
    .sample_in_i  (sample_in_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .chan_out_i   (chan_out_o),
    .sample_out_i (sample_out_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // idle length: mostly from the short range, now and then a long stretch
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // random register data
  function automatic logic [CFG_DATA_W-1:0] rand_data();
    return CFG_DATA_W'($urandom());
  endfunction

  // receiver back-pressure, changed only on the falling edge
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!out_quiet && $urandom_range(0, 99) < 20) begin
      stall_left  <= idle_len() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // sample source: mostly a slow walk per channel so the filters see tone-like input,
  // the rest full-range noise, the rails, zero and minus one
  function automatic logic signed [SB-1:0] pick_sample(logic [CHAN_W-1:0] ch);
    int unsigned r;
    longint v;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      v = walk[ch] + longint'($urandom_range(0, 2 * SLEW)) - SLEW;
      v = (v > SAMPLE_MAX) ? SAMPLE_MAX : ((v < SAMPLE_MIN) ? SAMPLE_MIN : v);
      walk[ch] = v;
      return v[SB-1:0];
    end
    if (r < 85) return SB'($urandom());
    case ($urandom_range(0, 3))
      0:       return SAMPLE_MAX[SB-1:0];
      1:       return SAMPLE_MIN[SB-1:0];
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // present one word and hold it until taken; called and returns on a falling edge.
  // valid stays high into the next word unless a gap is asked for
  task automatic send_word(input logic [CHAN_W-1:0] ch, input logic signed [SB-1:0] s,
                           input int gap);
    in_valid_i  <= 1'b1;
    chan_i      <= ch;
    sample_in_i <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // one register write; valid is left high for a following write
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // sender goes quiet, then every expected word has to come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // new register setting, only with the block empty; the spare indexes get noise too
  task automatic set_eq(input logic [CFG_DATA_W-1:0] lc, input logic [CFG_DATA_W-1:0] hc,
                        input logic [CFG_DATA_W-1:0] lg, input logic [CFG_DATA_W-1:0] mg,
                        input logic [CFG_DATA_W-1:0] hg);
    wait_drained();
    put_reg(REG_LOW_COEF, lc);
    put_reg(REG_HIGH_COEF, hc);
    put_reg(REG_LOW_GAIN, lg);
    put_reg(REG_MID_GAIN, mg);
    put_reg(REG_HIGH_GAIN, hg);
    for (int r = REG_SPARE_FIRST; r <= REG_SPARE_LAST; r++)
      put_reg(r[CFG_IDX_W-1:0], rand_data());
    cfg_valid_i <= 1'b0;
    settings++;
    @(negedge clk_i);
  endtask

  initial begin
    logic [CHAN_W-1:0] ch;
    int gap;

    // every input known from time zero
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    chan_i      = '0;
    sample_in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_LOW_COEF;
    cfg_data_i  = '0;
    foreach (walk[c]) walk[c] = 0;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, reset setting: full-scale step on every channel, then rails, zero and
    // minus one on channel 3's three-word delay, alternating bit patterns on channel 5
    for (int c = 0; c < (1 << CHAN_W); c++) send_word(c[CHAN_W-1:0], SAMPLE_MAX[SB-1:0], 0);
    send_word(3, SAMPLE_MIN[SB-1:0], 0);
    send_word(3, SAMPLE_MIN[SB-1:0], 0);
    send_word(3, '0, 0);
    send_word(3, '1, 0);
    send_word(3, SAMPLE_MAX[SB-1:0], 0);
    send_word(5, 24'h555555, 0);
    send_word(5, 24'hAAAAAA, 0);

    // directed, unstable poles: top coefficients drive the cascades into saturation,
    // full gains push the sum onto the output rails
    set_eq(COEF_MAX, COEF_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
    for (int k = 0; k < 4; k++) begin
      send_word(6, (k % 2) ? SAMPLE_MIN[SB-1:0] : SAMPLE_MAX[SB-1:0], 0);
      send_word(7, SAMPLE_MAX[SB-1:0], 0);
    end

    // random phases, each with its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: set_eq(rand_data(), rand_data(), rand_data(), rand_data(), rand_data());
        1: set_eq('0, '0, '0, '0, '0);
        2: set_eq(COEF_MAX, COEF_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
        3: set_eq(CFG_DATA_W'($urandom_range(0, 70000)),
                  CFG_DATA_W'($urandom_range(0, 70000)),
                  CFG_DATA_W'($urandom_range(0, 20'h3FFFF)),
                  CFG_DATA_W'($urandom_range(0, 20'h3FFFF)),
                  CFG_DATA_W'($urandom_range(0, 20'h3FFFF)));
        4: set_eq(rand_data(), rand_data(), rand_data(), rand_data(), rand_data());
        default: set_eq(LOW_COEF_RST, HIGH_COEF_RST, GAIN_RST, GAIN_RST, GAIN_RST);
      endcase
      // phases 1 and the last send words back to back with no idling on either side
      in_quiet  = (ph == 1 || ph == NUM_PHASES - 1);
      out_quiet = in_quiet;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // bursts on one channel keep its history busy, then hop elsewhere
        ch = ($urandom_range(0, 99) < 50) ? last_chan : CHAN_W'($urandom());
        last_chan = ch;
        gap = (!in_quiet && $urandom_range(0, 99) < 30) ? idle_len() : 0;
        send_word(ch, pick_sample(ch), gap);
      end
    end
    in_valid_i <= 1'b0;

    wait_drained();
    $display("covered %0d samples on all %0d channels under %0d register settings,",
             words_sent, 1 << CHAN_W, settings);
    $display("  rails, full gains, saturating poles, gaps and stalls; %0d words checked",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
